// File: hdl/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg
// Shared types, constants and helpers for the indexed sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package isb_pkg;

  localparam int PALETTES    = 64;
  localparam int MAX_CANVAS  = 16384;
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PALETTES);
  localparam int IDX_W       = $clog2(PAL_ENTRIES);
  localparam int MEM_AW      = PAL_AW + IDX_W;
  localparam int CANVAS_W    = 15;
  localparam int COORD_W     = 14;
  localparam int POS_W       = 18;
  localparam int ADDR_W      = 28;
  localparam int PROD_W      = COORD_W + CANVAS_W;

  localparam logic [31:0] OPAQUE    = 32'hFF00_0000;
  localparam logic [31:0] GREY_STEP = 32'h0001_0101;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1,
    CFG_PALETTE_COUNT = 2'd2
  } cfg_idx_t;

  // geometry and colour of one draw beat, before canvas clipping
  typedef struct packed {
    logic                    keep;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic [31:0]             color;
  } map_t;

  // clipped pixel, ready for the address multiply
  typedef struct packed {
    logic               keep;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [31:0]        color;
  } clip_t;

  function automatic logic [CANVAS_W-1:0] clamp_canvas(input logic [CANVAS_W-1:0] v);
    logic [CANVAS_W-1:0] r;
    if (v == '0) begin
      r = CANVAS_W'(1);
    end else if (v > CANVAS_W'(MAX_CANVAS)) begin
      r = CANVAS_W'(MAX_CANVAS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [31:0] grey_color(input logic [IDX_W-1:0] idx);
    logic [31:0] g;
    g = OPAQUE | ({24'd0, idx} * GREY_STEP);
    return g;
  endfunction

endpackage

`default_nettype wire

// File: hdl/isb_palette_ram.sv
// ----------------------------------------------------------------------------
// isb_palette_ram
// Palette colour memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module isb_palette_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [isb_pkg::MEM_AW-1:0] waddr,
  input  wire logic [31:0]               wdata,
  input  wire logic                      re,
  input  wire logic [isb_pkg::MEM_AW-1:0] raddr,
  output logic [31:0]                    rdata
);
  import isb_pkg::*;

  logic [31:0] mem [PALETTES*PAL_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/isb_map.sv
// ----------------------------------------------------------------------------
// isb_map
// Mirrors and offsets the source coordinates and picks the pixel colour.
// ----------------------------------------------------------------------------
`default_nettype none

module isb_map (
  input  wire logic                         command,
  input  wire logic [7:0]                   palette_number,
  input  wire logic [7:0]                   color_index,
  input  wire logic signed [15:0]           object_x,
  input  wire logic signed [15:0]           object_y,
  input  wire logic [14:0]                  object_width,
  input  wire logic [14:0]                  object_height,
  input  wire logic                         flip_horizontal,
  input  wire logic                         flip_vertical,
  input  wire logic [13:0]                  source_x,
  input  wire logic [13:0]                  source_y,
  input  wire logic [31:0]                  pal_data,
  input  wire logic [6:0]                   palette_count,
  output isb_pkg::map_t                     m
);
  import isb_pkg::*;

  logic [14:0] off_x;
  logic [14:0] off_y;
  logic        inside_src;
  logic        usable;

  // mirrored offsets wrap when the pixel is outside its object, but it is dropped then
  always_comb begin
    off_x = flip_horizontal ? (object_width - 15'd1 - {1'b0, source_x}) : {1'b0, source_x};
    off_y = flip_vertical ? (object_height - 15'd1 - {1'b0, source_y}) : {1'b0, source_y};
    inside_src = ({1'b0, source_x} < object_width) && ({1'b0, source_y} < object_height);
    usable = (palette_number < {1'b0, palette_count}) &&
             ({1'b0, palette_number} < 9'(PALETTES));

    m.keep  = (cmd_t'(command) == CMD_DRAW) && inside_src && (color_index != 8'd0);
    m.dx    = POS_W'(object_x) + $signed({3'b000, off_x});
    m.dy    = POS_W'(object_y) + $signed({3'b000, off_y});
    m.color = usable ? pal_data : grey_color(color_index);
  end

endmodule

`default_nettype wire

// File: hdl/isb_clip.sv
// ----------------------------------------------------------------------------
// isb_clip
// Drops pixels that fall outside the canvas.
// ----------------------------------------------------------------------------
`default_nettype none

module isb_clip (
  input  wire isb_pkg::map_t                   m,
  input  wire logic [isb_pkg::CANVAS_W-1:0]    canvas_w,
  input  wire logic [isb_pkg::CANVAS_W-1:0]    canvas_h,
  output isb_pkg::clip_t                       c
);
  import isb_pkg::*;

  logic in_x;
  logic in_y;

  always_comb begin
    in_x = !m.dx[POS_W-1] && (m.dx[POS_W-2:0] < {2'b00, canvas_w});
    in_y = !m.dy[POS_W-1] && (m.dy[POS_W-2:0] < {2'b00, canvas_h});
    c.keep  = m.keep && in_x && in_y;
    c.row   = m.dy[COORD_W-1:0];
    c.col   = m.dx[COORD_W-1:0];
    c.color = m.color;
  end

endmodule

`default_nettype wire

// File: hdl/indexed_sprite_blit_core.sv
// ----------------------------------------------------------------------------
// indexed_sprite_blit_core
// Palettized sprite blitter: palette loads and per-pixel canvas writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one command beat per cycle while in_stall is low:
//   a load writes color_value into palette entry palette_number:color_index,
//   a draw maps one source pixel onto the canvas.
//   Output channel (out_valid / out_stall) gives one beat for every input
//   beat, in order: write_enable, canvas_address and pixel_color, all zero
//   for loads and dropped pixels.
//   Throughput is one beat per clock while out_stall is low; the pipeline
//   has four registers (input/palette read, mapping, clip and row
//   multiply, address add).
//   When out_stall is high the stages fill up behind the output register,
//   and in_stall rises only once every stage holds a beat.
//   Configuration (cfg_wr_en, cfg_index, cfg_data) is written while idle;
//   canvas sizes are clamped to 1..16384 on write.
//   Reset empties the pipeline and sets the canvas to 1x1 and no palettes.
//   Palette memory is not cleared; load an entry before drawing with it.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_sprite_blit_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic [7:0]         palette_number,
  input  wire logic [7:0]         color_index,
  input  wire logic [31:0]        color_value,
  input  wire logic signed [15:0] object_x,
  input  wire logic signed [15:0] object_y,
  input  wire logic [14:0]        object_width,
  input  wire logic [14:0]        object_height,
  input  wire logic               flip_horizontal,
  input  wire logic               flip_vertical,
  input  wire logic [13:0]        source_x,
  input  wire logic [13:0]        source_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    write_enable,
  output logic [27:0]             canvas_address,
  output logic [31:0]             pixel_color
);
  import isb_pkg::*;

  // configuration
  logic [CANVAS_W-1:0] canvas_w;
  logic [CANVAS_W-1:0] canvas_h;
  logic [6:0]          palette_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w      <= CANVAS_W'(1);
      canvas_h      <= CANVAS_W'(1);
      palette_count <= 7'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CANVAS_WIDTH:  canvas_w      <= clamp_canvas(cfg_data);
        CFG_CANVAS_HEIGHT: canvas_h      <= clamp_canvas(cfg_data);
        CFG_PALETTE_COUNT: palette_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1, v2, v3;
  logic rdy_o, rdy3, rdy2, rdy1;
  logic in_accept;

  assign rdy_o     = !out_valid || !out_stall;
  assign rdy3      = !v3 || rdy_o;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_stall  = !rdy1;
  assign in_accept = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_o) begin
        out_valid <= v3;
      end
    end
  end

  // palette memory, accessed in beat order at the accept edge
  logic              pal_we;
  logic [MEM_AW-1:0] pal_addr;
  logic [31:0]       pal_data;

  assign pal_addr = {palette_number[PAL_AW-1:0], color_index};
  assign pal_we   = in_accept && (cmd_t'(command) == CMD_LOAD) &&
                    ({1'b0, palette_number} < 9'(PALETTES));

  isb_palette_ram u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_addr),
    .wdata (color_value),
    .re    (in_accept),
    .raddr (pal_addr),
    .rdata (pal_data)
  );

  // stage 1: input register
  logic               s1_command;
  logic [7:0]         s1_palette_number;
  logic [7:0]         s1_color_index;
  logic signed [15:0] s1_object_x;
  logic signed [15:0] s1_object_y;
  logic [14:0]        s1_object_width;
  logic [14:0]        s1_object_height;
  logic               s1_flip_horizontal;
  logic               s1_flip_vertical;
  logic [13:0]        s1_source_x;
  logic [13:0]        s1_source_y;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_command         <= command;
      s1_palette_number  <= palette_number;
      s1_color_index     <= color_index;
      s1_object_x        <= object_x;
      s1_object_y        <= object_y;
      s1_object_width    <= object_width;
      s1_object_height   <= object_height;
      s1_flip_horizontal <= flip_horizontal;
      s1_flip_vertical   <= flip_vertical;
      s1_source_x        <= source_x;
      s1_source_y        <= source_y;
    end
  end

  map_t map_next;

  isb_map u_map (
    .command         (s1_command),
    .palette_number  (s1_palette_number),
    .color_index     (s1_color_index),
    .object_x        (s1_object_x),
    .object_y        (s1_object_y),
    .object_width    (s1_object_width),
    .object_height   (s1_object_height),
    .flip_horizontal (s1_flip_horizontal),
    .flip_vertical   (s1_flip_vertical),
    .source_x        (s1_source_x),
    .source_y        (s1_source_y),
    .pal_data        (pal_data),
    .palette_count   (palette_count),
    .m               (map_next)
  );

  // stage 2: mapped pixel
  map_t s2_map;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_map <= map_next;
    end
  end

  clip_t clip_next;

  isb_clip u_clip (
    .m        (s2_map),
    .canvas_w (canvas_w),
    .canvas_h (canvas_h),
    .c        (clip_next)
  );

  // stage 3: row times stride
  logic               s3_keep;
  logic [PROD_W-1:0]  s3_prod;
  logic [COORD_W-1:0] s3_col;
  logic [31:0]        s3_color;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_keep  <= clip_next.keep;
      s3_prod  <= PROD_W'(clip_next.row) * PROD_W'(canvas_w);
      s3_col   <= clip_next.col;
      s3_color <= clip_next.color;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy_o) begin
      write_enable   <= s3_keep;
      canvas_address <= s3_keep ? (s3_prod[ADDR_W-1:0] + ADDR_W'(s3_col)) : '0;
      pixel_color    <= s3_keep ? s3_color : 32'd0;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_sprite_blit_core: palette loads and pixel
// draws go in under random bursts and output stalls, and every output beat
// is checked against a cycle-free prediction of palette lookup, mirroring,
// clipping and canvas addressing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import isb_pkg::*;

  typedef struct packed {
    cmd_t               command;
    logic [7:0]         palette_number;
    logic [7:0]         color_index;
    logic [31:0]        color_value;
    logic signed [15:0] object_x;
    logic signed [15:0] object_y;
    logic [14:0]        object_width;
    logic [14:0]        object_height;
    logic               flip_horizontal;
    logic               flip_vertical;
    logic [13:0]        source_x;
    logic [13:0]        source_y;
  } blit_cmd_t;

  typedef struct packed {
    logic        write_enable;
    logic [27:0] canvas_address;
    logic [31:0] pixel_color;
  } canvas_write_t;

  typedef enum {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

  // palette mirror, canvas settings and the canvas writes still owed
  class canvas_write_checker;
    logic [31:0]   palette_shadow [PALETTES*PAL_ENTRIES];
    int            canvas_w;
    int            canvas_h;
    int            palette_limit;
    canvas_write_t expected_writes [$];
    int            faults;
    int            checked;
    int            loads;
    int            written;
    int            greys;
    int            dropped;

    function new();
      canvas_w      = 1;
      canvas_h      = 1;
      palette_limit = 0;
      faults        = 0;
      checked       = 0;
      loads         = 0;
      written       = 0;
      greys         = 0;
      dropped       = 0;
      foreach (palette_shadow[i]) palette_shadow[i] = '0;
    endfunction

    function int extent(input logic [14:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_CANVAS) return MAX_CANVAS;
      return int'(v);
    endfunction

    function void write_register(input cfg_idx_t idx, input logic [14:0] data);
      case (idx)
        CFG_CANVAS_WIDTH: canvas_w = extent(data);
        CFG_CANVAS_HEIGHT: canvas_h = extent(data);
        CFG_PALETTE_COUNT: begin
          palette_limit = (int'(data[6:0]) < PALETTES) ? int'(data[6:0]) : PALETTES;
        end
        default: ;
      endcase
    endfunction

    function void take_command(input blit_cmd_t c);
      canvas_write_t px;
      int            ow;
      int            oh;
      int            sx;
      int            sy;
      int            col;
      int            row;
      px = '0;
      if (c.command == CMD_LOAD) begin
        loads++;
        if (int'(c.palette_number) < PALETTES) begin
          palette_shadow[int'(c.palette_number) * PAL_ENTRIES + int'(c.color_index)] =
            c.color_value;
        end
      end else begin
        ow = int'(c.object_width);
        oh = int'(c.object_height);
        sx = int'(c.source_x);
        sy = int'(c.source_y);
        col = int'($signed(c.object_x)) + (c.flip_horizontal ? ow - 1 - sx : sx);
        row = int'($signed(c.object_y)) + (c.flip_vertical ? oh - 1 - sy : sy);
        if (sx < ow && sy < oh && c.color_index != '0 &&
            col >= 0 && col < canvas_w && row >= 0 && row < canvas_h) begin
          px.write_enable   = 1'b1;
          px.canvas_address = 28'(row * canvas_w + col);
          if (int'(c.palette_number) < palette_limit) begin
            px.pixel_color =
              palette_shadow[int'(c.palette_number) * PAL_ENTRIES + int'(c.color_index)];
          end else begin
            px.pixel_color = OPAQUE | ({24'd0, c.color_index} * GREY_STEP);
            greys++;
          end
          written++;
        end else begin
          dropped++;
        end
      end
      expected_writes.push_back(px);
    endfunction

    function void check_canvas_write(input canvas_write_t got);
      canvas_write_t want;
      checked++;
      if (expected_writes.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("output beat %0d with no command pending: we=%0b addr=%0d color=%08h",
                   checked, got.write_enable, got.canvas_address, got.pixel_color);
        end
        return;
      end
      want = expected_writes.pop_front();
      if (got.write_enable !== want.write_enable ||
          got.canvas_address !== want.canvas_address ||
          got.pixel_color !== want.pixel_color) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch on output beat %0d: expected we=%0b addr=%0d color=%08h",
                   checked, want.write_enable, want.canvas_address, want.pixel_color);
          $display("                          got      we=%0b addr=%0d color=%08h",
                   got.write_enable, got.canvas_address, got.pixel_color);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  cfg_idx_t           cfg_index = CFG_CANVAS_WIDTH;
  logic [14:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cmd_t               command = CMD_LOAD;
  logic [7:0]         palette_number = '0;
  logic [7:0]         color_index = '0;
  logic [31:0]        color_value = '0;
  logic signed [15:0] object_x = '0;
  logic signed [15:0] object_y = '0;
  logic [14:0]        object_width = '0;
  logic [14:0]        object_height = '0;
  logic               flip_horizontal = 1'b0;
  logic               flip_vertical = 1'b0;
  logic [13:0]        source_x = '0;
  logic [13:0]        source_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               write_enable;
  logic [27:0]        canvas_address;
  logic [31:0]        pixel_color;

  canvas_write_checker sb;
  bit                  palette_loaded [PALETTES*PAL_ENTRIES];
  int                  burst_left = 0;
  bit                  sender_gaps = 1'b1;
  int                  phases = 0;
  rx_mode_t            rx_mode = RX_STREAM;
  int                  rx_hold = 0;
  int                  rx_run = 0;

  indexed_sprite_blit_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .palette_number  (palette_number),
    .color_index     (color_index),
    .color_value     (color_value),
    .object_x        (object_x),
    .object_y        (object_y),
    .object_width    (object_width),
    .object_height   (object_height),
    .flip_horizontal (flip_horizontal),
    .flip_vertical   (flip_vertical),
    .source_x        (source_x),
    .source_y        (source_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .write_enable    (write_enable),
    .canvas_address  (canvas_address),
    .pixel_color     (pixel_color)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin : observe
    blit_cmd_t     seen;
    canvas_write_t got;
    if (!rst) begin
      if (cfg_wr_en) sb.write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        seen = '{command, palette_number, color_index, color_value, object_x, object_y,
                 object_width, object_height, flip_horizontal, flip_vertical,
                 source_x, source_y};
        sb.take_command(seen);
      end
      if (out_valid && !out_stall) begin
        got = '{write_enable, canvas_address, pixel_color};
        sb.check_canvas_write(got);
      end
    end
  end

  // receiver: stall behavior switches at random among stream, light, heavy and bursty modes
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_hold == 0) begin
        rx_mode = rx_mode_t'($urandom_range(3, 0));
        rx_hold = $urandom_range(300, 40);
      end
      rx_hold--;
      case (rx_mode)
        RX_STREAM: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
        default: begin
          if (rx_run == 0) begin
            out_stall <= !out_stall;
            rx_run = $urandom_range(12, 1);
          end else begin
            rx_run--;
          end
        end
      endcase
    end
  end

  function automatic blit_cmd_t load_cmd(input int pal, input int idx,
                                         input logic [31:0] value);
    blit_cmd_t c;
    c                = '0;
    c.command        = CMD_LOAD;
    c.palette_number = 8'(pal);
    c.color_index    = 8'(idx);
    c.color_value    = value;
    return c;
  endfunction

  function automatic blit_cmd_t draw_cmd(input int pal, input int idx, input int ox,
                                         input int oy, input int ow, input int oh,
                                         input bit hf, input bit vf, input int sx,
                                         input int sy);
    blit_cmd_t c;
    c                 = '0;
    c.command         = CMD_DRAW;
    c.palette_number  = 8'(pal);
    c.color_index     = 8'(idx);
    c.color_value     = $urandom();
    c.object_x        = 16'(ox);
    c.object_y        = 16'(oy);
    c.object_width    = 15'(ow);
    c.object_height   = 15'(oh);
    c.flip_horizontal = hf;
    c.flip_vertical   = vf;
    c.source_x        = 14'(sx);
    c.source_y        = 14'(sy);
    return c;
  endfunction

  // mostly small sprites, now and then a huge one
  function automatic int object_extent();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 80) return $urandom_range(64, 1);
    if (pick < 95) return $urandom_range(512, 1);
    return $urandom_range(MAX_CANVAS, 1);
  endfunction

  function automatic blit_cmd_t random_command();
    blit_cmd_t c;
    int        pick;
    int        ow;
    int        oh;
    // start from noise in every field but the command
    c.command         = CMD_DRAW;
    c.palette_number  = 8'($urandom());
    c.color_index     = 8'($urandom());
    c.color_value     = $urandom();
    c.object_x        = 16'($urandom());
    c.object_y        = 16'($urandom());
    c.object_width    = 15'($urandom());
    c.object_height   = 15'($urandom());
    c.flip_horizontal = 1'($urandom());
    c.flip_vertical   = 1'($urandom());
    c.source_x        = 14'($urandom());
    c.source_y        = 14'($urandom());
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      c.command = CMD_LOAD;
      if ($urandom_range(9, 0) != 0) c.palette_number = 8'($urandom_range(PALETTES - 1, 0));
    end else if (pick < 85) begin
      // source pixel inside its sprite, sprite placed around the canvas
      ow = object_extent();
      oh = object_extent();
      c.object_width  = 15'(ow);
      c.object_height = 15'(oh);
      c.source_x      = 14'($urandom_range(ow - 1, 0));
      c.source_y      = 14'($urandom_range(oh - 1, 0));
      c.object_x      = 16'(int'($urandom_range(sb.canvas_w + ow, 0)) - ow);
      c.object_y      = 16'(int'($urandom_range(sb.canvas_h + oh, 0)) - oh);
      pick = $urandom_range(99, 0);
      if (pick < 10) c.color_index = '0;
      else if (pick < 55) c.color_index = 8'($urandom_range(15, 1));
      else c.color_index = 8'($urandom_range(255, 1));
      pick = $urandom_range(99, 0);
      if (pick < 60 && sb.palette_limit > 0) begin
        c.palette_number = 8'($urandom_range(sb.palette_limit - 1, 0));
      end else if (pick < 85) begin
        c.palette_number = 8'($urandom_range(PALETTES - 1, 0));
      end else begin
        c.palette_number = 8'($urandom_range(255, PALETTES));
      end
    end
    return c;
  endfunction

  task automatic send_command(input blit_cmd_t c);
    command         <= c.command;
    palette_number  <= c.palette_number;
    color_index     <= c.color_index;
    color_value     <= c.color_value;
    object_x        <= c.object_x;
    object_y        <= c.object_y;
    object_width    <= c.object_width;
    object_height   <= c.object_height;
    flip_horizontal <= c.flip_horizontal;
    flip_vertical   <= c.flip_vertical;
    source_x        <= c.source_x;
    source_y        <= c.source_y;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      if (sender_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(negedge clk);
      end
    end
  endtask

  // a draw from a usable palette never reads an entry that was not loaded
  task automatic issue(input blit_cmd_t c);
    blit_cmd_t fill;
    int        entry;
    entry = int'(c.palette_number) * PAL_ENTRIES + int'(c.color_index);
    if (c.command == CMD_DRAW && int'(c.palette_number) < sb.palette_limit &&
        !palette_loaded[entry]) begin
      fill             = c;
      fill.command     = CMD_LOAD;
      fill.color_value = $urandom();
      palette_loaded[entry] = 1'b1;
      send_command(fill);
    end
    if (c.command == CMD_LOAD && int'(c.palette_number) < PALETTES) begin
      palette_loaded[entry] = 1'b1;
    end
    send_command(c);
  endtask

  // wait until every beat is out, then let the pipeline run dry
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_writes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [14:0] width, input logic [14:0] height,
                           input logic [14:0] count, input int items, input bit gaps);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_CANVAS_WIDTH;
    cfg_data  <= width;
    @(negedge clk);
    cfg_index <= CFG_CANVAS_HEIGHT;
    cfg_data  <= height;
    @(negedge clk);
    cfg_index <= CFG_PALETTE_COUNT;
    cfg_data  <= count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sender_gaps = gaps;
    phases++;
    repeat (items) issue(random_command());
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 32x16 canvas, four palettes usable
    run_phase(15'd32, 15'd16, 15'd4, 0, 1'b1);
    issue(load_cmd(0, 1, 32'h1234_5678));
    issue(load_cmd(0, 255, 32'hFFFF_FFFF));
    issue(load_cmd(3, 0, 32'h0000_0000));
    issue(load_cmd(63, 255, 32'h8000_0001));
    issue(load_cmd(255, 9, 32'h5555_AAAA));  // beyond palette memory, ignored
    issue(draw_cmd(0, 1, 0, 0, 1, 1, 0, 0, 0, 0));
    issue(draw_cmd(0, 255, 31, 15, 1, 1, 0, 0, 0, 0));
    issue(draw_cmd(0, 0, 2, 2, 4, 4, 0, 0, 1, 1));  // transparent
    issue(draw_cmd(4, 255, 5, 5, 1, 1, 0, 0, 0, 0));  // palette at the count: grey
    issue(draw_cmd(255, 1, 0, 0, 1, 1, 0, 0, 0, 0));
    issue(draw_cmd(63, 255, 3, 3, 1, 1, 0, 0, 0, 0));
    issue(draw_cmd(0, 1, 0, 0, 8, 4, 1, 0, 0, 0));
    issue(draw_cmd(0, 1, 0, 0, 8, 4, 0, 1, 0, 0));
    issue(draw_cmd(0, 1, 4, 4, 8, 4, 1, 1, 2, 1));
    issue(draw_cmd(0, 1, 0, 0, 8, 4, 0, 0, 8, 0));  // column past sprite width
    issue(draw_cmd(0, 1, 0, 0, 8, 4, 0, 0, 0, 4));  // row past sprite height
    issue(draw_cmd(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));  // empty sprite
    issue(draw_cmd(0, 1, -1, 0, 4, 1, 0, 0, 1, 0));
    issue(draw_cmd(0, 1, -32768, -32768, 32767, 32767, 1, 1, 16383, 16383));
    issue(draw_cmd(0, 1, 32767, 32767, 4, 4, 0, 0, 0, 0));
    issue(draw_cmd(0, 1, -16383, -16383, 32767, 32767, 0, 0, 16383, 16383));
    issue(draw_cmd(0, 1, 32, 0, 1, 1, 0, 0, 0, 0));  // just right of canvas
    issue(draw_cmd(0, 1, 0, 16, 1, 1, 0, 0, 0, 0));  // just below canvas
    issue(draw_cmd(3, 0, 1, 1, 1, 1, 0, 0, 0, 0));

    run_phase(15'd0, 15'd0, 15'd0, 60, 1'b0);
    run_phase(15'd16384, 15'd16384, 15'd64, 110, 1'b1);
    run_phase(15'd32767, 15'd100, 15'd127, 75, 1'b0);
    run_phase(15'd640, 15'd480, 15'($urandom_range(64, 1)), 150, 1'b1);
    repeat (4) begin
      run_phase(15'($urandom_range(64, 1)), 15'($urandom_range(64, 1)),
                15'($urandom_range(32767, 0)), 75, 1'($urandom()));
    end
    settle();

    $display("%0d commands in %0d canvas settings: %0d palette loads, %0d pixels dropped",
             sb.checked, phases, sb.loads, sb.dropped);
    $display("%0d canvas writes checked, %0d of them with the grey fallback",
             sb.written, sb.greys);
    if (sb.faults == 0) begin
      $display("** indexed_sprite_blit_core: PASSED **");
    end else begin
      $display("** indexed_sprite_blit_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats still owed", sb.expected_writes.size());
    $display("** indexed_sprite_blit_core: FAILED **");
    $finish;
  end

endmodule
